/* rtl/som_pkg.sv */
`default_nettype none

package som_pkg;

  localparam int unsigned PixW      = 16;
  localparam int unsigned GainW     = 32;
  localparam int unsigned CapW      = 6;
  localparam int unsigned CmpW      = CapW + 1;
  localparam int unsigned FracW     = 8;
  localparam int unsigned NumW      = GainW + PixW;
  localparam int unsigned ProdW     = 2 * PixW;
  localparam int unsigned DenW      = ProdW + FracW;
  localparam int unsigned RemW      = NumW + 1;
  localparam int unsigned QuotW     = CapW;
  localparam int unsigned StepW     = 3;
  localparam int unsigned DataW     = 32;
  localparam int unsigned AddrW     = 4;
  localparam int unsigned DefWindow = 32;

  localparam logic             RstSideLeft = 1'b0;
  localparam logic [PixW-1:0]  RstMinJump  = 16'd20;
  localparam logic [GainW-1:0] RstGain     = 32'd5120000;
  localparam logic [CapW-1:0]  RstMaxWidth = 6'd8;

  typedef enum logic [1:0] {
    RegSideLeft,
    RegMinJump,
    RegGain,
    RegMaxWidth
  } reg_idx_e;

  typedef struct packed {
    logic             side_left;
    logic [PixW-1:0]  min_jump_raw;
    logic [GainW-1:0] occlusion_gain;
    logic [CapW-1:0]  max_width;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/stereo_occlusion_masker_unit.sv */
// Stereo occlusion masker. Raw 16-bit depth pixels enter in row order on the s_axis
// side (tlast marks the last pixel of a row) and leave delayed through a window of up
// to max_width pixels (clamped to 1..WINDOW) on the m_axis side, zeroed where they fall
// in the occluded band beside a depth edge; m_axis_tlast marks the last pixel of a row
// and m_axis_tuser the last pixel released by a given input pixel, and an input may
// release none. One pixel is handled at a time: s_axis_tready is high only between
// pixels. When an edge is found, the occlusion width is worked out by a single 49-bit
// compare-subtract unit, one quotient bit per cycle, stopping early when the width
// saturates; each released pixel is held until the sink takes it. The window is a
// RAM of WINDOW entries written once per pixel and read once per released pixel.
// Registers sit on the APB port at byte addresses 0 (side_left), 4 (min_jump_raw),
// 8 (occlusion_gain, 8 fraction bits) and 12 (max_width); write them only while idle.
`default_nettype none

module stereo_occlusion_masker_unit
  import som_pkg::*;
#(
  parameter int unsigned WINDOW = DefWindow
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // APB configuration
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  // input pixels
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [PixW-1:0]  s_axis_tdata,   // [15:0] depth_in
  input  wire logic             s_axis_tlast,   // row_end
  // output pixels
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic      [PixW-1:0]  m_axis_tdata,   // [15:0] depth_out
  output logic                  m_axis_tlast,   // out_row_end
  output logic                  m_axis_tuser    // [0] burst_last
);

  localparam int unsigned IdxW  = $clog2(WINDOW);
  localparam int unsigned FillW = $clog2(WINDOW + 1);

  typedef enum logic [2:0] {
    SIdle,
    SEval,
    SWait,
    SMark,
    SPush,
    SRead,
    SLoad,
    SOut
  } state_e;

  cfg_t             cfg;
  state_e           state_q, state_d;
  logic [PixW-1:0]  cur_q, cur_d;
  logic             rowend_q, rowend_d;
  logic [PixW-1:0]  prev_q, prev_d;
  logic             started_q, started_d;
  logic [CapW-1:0]  w_q, w_d;
  logic [CapW-1:0]  fwd_q, fwd_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [IdxW-1:0]  head_q, head_d;
  logic [WINDOW-1:0] marks_q, marks_d;
  logic             curmark_q, curmark_d;
  logic             pend_q, pend_d;
  logic             last_q, last_d;
  logic             tvalid_q, tvalid_d;
  logic [PixW-1:0]  tdata_q, tdata_d;
  logic             tlast_q, tlast_d;
  logic             tuser_q, tuser_d;

  logic [CapW-1:0]  cap;
  logic [PixW-1:0]  far, near;
  logic             edge_hit;
  logic             div_start, div_done;
  logic [CapW-1:0]  div_width;
  logic [IdxW-1:0]  tail;
  logic [CmpW-1:0]  tail_sum;
  logic             ram_we, ram_re;
  logic [PixW-1:0]  ram_rdata;

  som_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  always_comb begin
    if (cfg.max_width == '0) begin
      cap = CapW'(1);
    end else if (cfg.max_width > CapW'(WINDOW)) begin
      cap = CapW'(WINDOW);
    end else begin
      cap = cfg.max_width;
    end
  end

  assign far  = cfg.side_left ? prev_q : cur_q;
  assign near = cfg.side_left ? cur_q : prev_q;
  assign edge_hit = started_q && (prev_q != '0) && (cur_q != '0) && (far >= near) &&
                    ((far - near) >= cfg.min_jump_raw);
  assign div_start = (state_q == SEval) && edge_hit;

  som_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .far_i   (far),
    .near_i  (near),
    .gain_i  (cfg.occlusion_gain),
    .cap_i   (cap),
    .done_o  (div_done),
    .width_o (div_width)
  );

  always_comb begin
    tail_sum = CmpW'(head_q) + CmpW'(fill_q);
    if (tail_sum >= CmpW'(WINDOW)) begin
      tail_sum = tail_sum - CmpW'(WINDOW);
    end
  end
  assign tail = tail_sum[IdxW-1:0];

  assign ram_we = (state_q == SPush);
  assign ram_re = (state_q == SRead);

  som_ram #(
    .Width (PixW),
    .Depth (WINDOW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail),
    .wdata_i (cur_q),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready = (state_q == SIdle);
  assign m_axis_tvalid = tvalid_q;
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tlast  = tlast_q;
  assign m_axis_tuser  = tuser_q;

  always_comb begin
    logic [CmpW-1:0] lpos;
    logic [CmpW-1:0] lo;
    logic [CmpW-1:0] run;
    logic            cur_mark;
    logic [CapW-1:0] fwd_dec;
    logic [FillW-1:0] fill_new;

    state_d   = state_q;
    cur_d     = cur_q;
    rowend_d  = rowend_q;
    prev_d    = prev_q;
    started_d = started_q;
    w_d       = w_q;
    fwd_d     = fwd_q;
    fill_d    = fill_q;
    head_d    = head_q;
    marks_d   = marks_q;
    curmark_d = curmark_q;
    pend_d    = pend_q;
    last_d    = last_q;
    tvalid_d  = tvalid_q;
    tdata_d   = tdata_q;
    tlast_d   = tlast_q;
    tuser_d   = tuser_q;

    run      = (CmpW'(w_q) < CmpW'(fill_q)) ? CmpW'(w_q) : CmpW'(fill_q);
    lo       = CmpW'(fill_q) - run;
    cur_mark = (fwd_q != '0);
    fwd_dec  = (fwd_q != '0) ? fwd_q - CapW'(1) : fwd_q;
    fill_new = fill_q + FillW'(1);
    lpos     = '0;

    unique case (state_q)
      SIdle: begin
        if (s_axis_tvalid) begin
          cur_d    = s_axis_tdata;
          rowend_d = s_axis_tlast;
          state_d  = SEval;
        end
      end
      SEval: begin
        w_d     = '0;
        state_d = edge_hit ? SWait : SMark;
      end
      SWait: begin
        if (div_done) begin
          w_d     = div_width;
          state_d = SMark;
        end
      end
      SMark: begin
        // left mode: mark the newest w held pixels, never more than the window holds
        if (cfg.side_left && w_q != '0) begin
          for (int p = 0; p < WINDOW; p++) begin
            if (CmpW'(p) >= CmpW'(head_q)) begin
              lpos = CmpW'(p) - CmpW'(head_q);
            end else begin
              lpos = CmpW'(p) + CmpW'(WINDOW) - CmpW'(head_q);
            end
            if (lpos < CmpW'(fill_q) && lpos >= lo) begin
              marks_d[p] = 1'b1;
            end
          end
        end
        // right mode: mark this pixel and carry the rest of the run forward
        if (!cfg.side_left && w_q != '0) begin
          cur_mark = 1'b1;
          if ((w_q - CapW'(1)) > fwd_dec) begin
            fwd_dec = w_q - CapW'(1);
          end
        end
        curmark_d = cur_mark;
        if (rowend_q) begin
          prev_d    = '0;
          started_d = 1'b0;
          fwd_d     = '0;
        end else begin
          prev_d    = cur_q;
          started_d = 1'b1;
          fwd_d     = fwd_dec;
        end
        // release down to one below the cap before making room for this pixel
        if (CmpW'(fill_q) >= CmpW'(cap)) begin
          pend_d  = 1'b1;
          state_d = SRead;
        end else begin
          state_d = SPush;
        end
      end
      SPush: begin
        marks_d[tail] = curmark_q;
        fill_d        = fill_new;
        pend_d        = 1'b0;
        state_d       = rowend_q ? SRead : SIdle;
      end
      SRead: state_d = SLoad;
      SLoad: begin
        tdata_d  = marks_q[head_q] ? '0 : ram_rdata;
        if (pend_q) begin
          last_d  = (CmpW'(fill_q) == CmpW'(cap));
          tlast_d = 1'b0;
          tuser_d = last_d && !rowend_q;
        end else begin
          last_d  = (fill_q == FillW'(1));
          tlast_d = last_d;
          tuser_d = last_d;
        end
        tvalid_d = 1'b1;
        fill_d   = fill_q - FillW'(1);
        head_d   = (head_q == IdxW'(WINDOW - 1)) ? '0 : head_q + IdxW'(1);
        state_d  = SOut;
      end
      SOut: begin
        // hold the request until the sink takes it
        if (m_axis_tready) begin
          tvalid_d = 1'b0;
          if (!last_q) begin
            state_d = SRead;
          end else if (pend_q) begin
            state_d = SPush;
          end else begin
            state_d = SIdle;
          end
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      cur_q     <= '0;
      rowend_q  <= 1'b0;
      prev_q    <= '0;
      started_q <= 1'b0;
      w_q       <= '0;
      fwd_q     <= '0;
      fill_q    <= '0;
      head_q    <= '0;
      marks_q   <= '0;
      curmark_q <= 1'b0;
      pend_q    <= 1'b0;
      last_q    <= 1'b0;
      tvalid_q  <= 1'b0;
      tdata_q   <= '0;
      tlast_q   <= 1'b0;
      tuser_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      cur_q     <= cur_d;
      rowend_q  <= rowend_d;
      prev_q    <= prev_d;
      started_q <= started_d;
      w_q       <= w_d;
      fwd_q     <= fwd_d;
      fill_q    <= fill_d;
      head_q    <= head_d;
      marks_q   <= marks_d;
      curmark_q <= curmark_d;
      pend_q    <= pend_d;
      last_q    <= last_d;
      tvalid_q  <= tvalid_d;
      tdata_q   <= tdata_d;
      tlast_q   <= tlast_d;
      tuser_q   <= tuser_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/som_ram.sv */
`default_nettype none

module som_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/som_cfg.sv */
`default_nettype none

module som_cfg
  import som_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel_i,
  input  wire logic             penable_i,
  input  wire logic             pwrite_i,
  input  wire logic [AddrW-1:0] paddr_i,
  input  wire logic [DataW-1:0] pwdata_i,
  output logic      [DataW-1:0] prdata_o,
  output logic                  pready_o,
  output cfg_t                  cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr;

  assign idx      = reg_idx_e'(paddr_i[AddrW-1:2]);
  assign wr       = psel_i & penable_i & pwrite_i & pready_o;
  assign pready_o = 1'b1;
  assign cfg_o    = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (idx)
        RegSideLeft: cfg_d.side_left      = pwdata_i[0];
        RegMinJump:  cfg_d.min_jump_raw   = pwdata_i[PixW-1:0];
        RegGain:     cfg_d.occlusion_gain = pwdata_i[GainW-1:0];
        RegMaxWidth: cfg_d.max_width      = pwdata_i[CapW-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegSideLeft: prdata_o = DataW'(cfg_q.side_left);
      RegMinJump:  prdata_o = DataW'(cfg_q.min_jump_raw);
      RegGain:     prdata_o = DataW'(cfg_q.occlusion_gain);
      RegMaxWidth: prdata_o = DataW'(cfg_q.max_width);
      default:     prdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.side_left      <= RstSideLeft;
      cfg_q.min_jump_raw   <= RstMinJump;
      cfg_q.occlusion_gain <= RstGain;
      cfg_q.max_width      <= RstMaxWidth;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/som_div.sv */
`default_nettype none

// Occlusion width: min(ceil(gain * (far - near) / ((near * far) << 8)), cap).
// One compare-subtract per cycle: a saturation check at bit QuotW, then quotient bits QuotW-1 down to 0.
module som_div
  import som_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [PixW-1:0]  far_i,
  input  wire logic [PixW-1:0]  near_i,
  input  wire logic [GainW-1:0] gain_i,
  input  wire logic [CapW-1:0]  cap_i,
  output logic                  done_o,
  output logic [CapW-1:0]       width_o
);

  typedef enum logic [2:0] {
    DIdle,
    DAdd,
    DIter,
    DDone
  } dstate_e;

  dstate_e           state_q, state_d;
  logic [NumW-1:0]   num_q, num_d;
  logic [ProdW-1:0]  den_q, den_d;
  logic [RemW-1:0]   rem_q, rem_d;
  logic [DenW-1:0]   dvs_q, dvs_d;
  logic [StepW-1:0]  k_q, k_d;
  logic [QuotW-1:0]  q_q, q_d;
  logic              sat_q, sat_d;
  logic [PixW-1:0]   diff;
  logic [RemW-1:0]   trial;
  logic              ge;

  assign diff  = far_i - near_i;
  assign trial = RemW'(dvs_q) << k_q;
  assign ge    = rem_q >= trial;

  assign done_o  = (state_q == DDone);
  assign width_o = (sat_q || q_q > cap_i) ? cap_i : q_q;

  always_comb begin
    state_d = state_q;
    num_d   = num_q;
    den_d   = den_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    k_d     = k_q;
    q_d     = q_q;
    sat_d   = sat_q;
    unique case (state_q)
      DIdle: begin
        if (start_i) begin
          num_d   = NumW'(gain_i) * NumW'(diff);
          den_d   = ProdW'(near_i) * ProdW'(far_i);
          state_d = DAdd;
        end
      end
      DAdd: begin
        // bias by divisor - 1 so that the floor quotient is the ceiling
        dvs_d   = {den_q, FracW'(0)};
        rem_d   = RemW'(num_q) + RemW'({den_q, FracW'(0)}) - RemW'(1);
        k_d     = StepW'(QuotW);
        q_d     = '0;
        sat_d   = 1'b0;
        state_d = DIter;
      end
      DIter: begin
        if (k_q == StepW'(QuotW)) begin
          // quotient beyond every legal cap: saturate
          if (ge) begin
            sat_d   = 1'b1;
            state_d = DDone;
          end else begin
            k_d = k_q - StepW'(1);
          end
        end else begin
          if (ge) begin
            rem_d = rem_q - trial;
            q_d   = q_q | (QuotW'(1) << k_q);
          end
          if (k_q == '0) begin
            state_d = DDone;
          end else begin
            k_d = k_q - StepW'(1);
          end
        end
      end
      DDone: state_d = DIdle;
      default: state_d = DIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIdle;
      num_q   <= '0;
      den_q   <= '0;
      rem_q   <= '0;
      dvs_q   <= '0;
      k_q     <= '0;
      q_q     <= '0;
      sat_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      num_q   <= num_d;
      den_q   <= den_d;
      rem_q   <= rem_d;
      dvs_q   <= dvs_d;
      k_q     <= k_d;
      q_q     <= q_d;
      sat_q   <= sat_d;
    end
  end

endmodule

`default_nettype wire
